>>> src/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared constants for the step-toward-target block.
// ----------------------------------------------------------------------------
package stt_pkg;

	localparam int SPEED_W = 8;
	localparam int APB_AW  = 2;
	localparam int APB_DW  = 32;

	localparam logic [SPEED_W-1:0] SPEED_RESET = 8'd25;

	typedef enum logic [APB_AW-1:0] {
		REG_SPEED = 2'd0
	} reg_addr_t;

endpackage

>>> src/stt_in_if.sv
// ----------------------------------------------------------------------------
// stt_in_if
// Input channel: position, target and active flag of one point.
// ----------------------------------------------------------------------------
interface stt_in_if #(
	parameter int COORD_BITS = 10
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pos_x;
	logic [COORD_BITS-1:0] pos_y;
	logic [COORD_BITS-1:0] tgt_x;
	logic [COORD_BITS-1:0] tgt_y;
	logic                  active;

	modport source (output valid, pos_x, pos_y, tgt_x, tgt_y, active, input ready);
	modport sink   (input valid, pos_x, pos_y, tgt_x, tgt_y, active, output ready);
endinterface

>>> src/stt_out_if.sv
// ----------------------------------------------------------------------------
// stt_out_if
// Output channel: position after one step and the moving flag.
// ----------------------------------------------------------------------------
interface stt_out_if #(
	parameter int COORD_BITS = 10
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] new_x;
	logic [COORD_BITS-1:0] new_y;
	logic                  still_moving;

	modport source (output valid, new_x, new_y, still_moving, input ready);
	modport sink   (input valid, new_x, new_y, still_moving, output ready);
endinterface

>>> src/step_toward_target_top.sv
// ----------------------------------------------------------------------------
// step_toward_target_top
// Moves an active point one speed-length step toward its target or onto it.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one point per item (pos, tgt, active); out_ch returns one
//   item per input item, in order (new position, still_moving).
//   The speed register sits at APB byte address 0; write it only while idle.
// Pipeline, from accept to result valid: three front stages
//   (abs diff, squares/products, sum/compare), one stage per root digit,
//   one stage per quotient bit of the two parallel dividers, one output stage.
// Throughput: one item per cycle when not stalled. All stages advance together.
// Stall: when out_ch is held (valid and not ready) the pipeline freezes and
//   in_ch.ready drops; nothing is lost or repeated. Bubbles are not squeezed.
// Reset: arst_n clears all valid bits and sets speed to 25.
// ----------------------------------------------------------------------------
module step_toward_target_top #(
	parameter int COORD_BITS = 10,
	parameter int FRAC_BITS  = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	stt_in_if.sink                     in_ch,
	stt_out_if.source                  out_ch,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [stt_pkg::APB_AW-1:0] paddr,
	input  logic [stt_pkg::APB_DW-1:0] pwdata,
	output logic [stt_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import stt_pkg::*;

	localparam int C   = COORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int P   = C + 1 + F;
	localparam int RW  = P + 3;
	localparam int QW  = SPEED_W + F;
	localparam int MW  = SPEED_W + C;
	localparam int NW  = MW + 2 * F;
	localparam int D2W = 2 * C + 1;
	localparam int CW  = (D2W > 2 * SPEED_W) ? D2W : 2 * SPEED_W;
	localparam int BW  = (C > SPEED_W) ? C : SPEED_W;
	localparam int SW  = BW + F + 1;

	typedef struct packed {
		logic [C-1:0]  px;
		logic [C-1:0]  py;
		logic [C-1:0]  tx;
		logic [C-1:0]  ty;
		logic          act;
		logic          snap;
		logic          dx;
		logic          dy;
		logic [MW-1:0] nx;
		logic [MW-1:0] ny;
	} ctx_t;

	// configuration
	logic [SPEED_W-1:0] speed_q;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_SPEED) ? {{(APB_DW-SPEED_W){1'b0}}, speed_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= SPEED_RESET;
		end else if (psel && penable && pwrite && paddr == REG_SPEED) begin
			speed_q <= pwdata[SPEED_W-1:0];
		end
	end

	// pipeline advance
	logic out_v_q;
	logic adv;

	assign adv         = !out_v_q || out_ch.ready;
	assign in_ch.ready = adv;

	// stage 1: absolute differences
	logic         v_s1;
	ctx_t         ctx_s1;
	logic [C-1:0] ax_s1, ay_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s1.px   <= in_ch.pos_x;
			ctx_s1.py   <= in_ch.pos_y;
			ctx_s1.tx   <= in_ch.tgt_x;
			ctx_s1.ty   <= in_ch.tgt_y;
			ctx_s1.act  <= in_ch.active;
			ctx_s1.snap <= 1'b0;
			ctx_s1.dx   <= in_ch.tgt_x >= in_ch.pos_x;
			ctx_s1.dy   <= in_ch.tgt_y >= in_ch.pos_y;
			ctx_s1.nx   <= '0;
			ctx_s1.ny   <= '0;
			ax_s1 <= (in_ch.tgt_x >= in_ch.pos_x) ? in_ch.tgt_x - in_ch.pos_x
			                                      : in_ch.pos_x - in_ch.tgt_x;
			ay_s1 <= (in_ch.tgt_y >= in_ch.pos_y) ? in_ch.tgt_y - in_ch.pos_y
			                                      : in_ch.pos_y - in_ch.tgt_y;
		end
	end

	// stage 2: squares and speed products
	logic                   v_s2;
	ctx_t                   ctx_s2;
	ctx_t                   ctx_s2_d;
	logic [2*C-1:0]         sqx_s2, sqy_s2;
	logic [2*SPEED_W-1:0]   spd2_s2;

	always_comb begin
		ctx_s2_d    = ctx_s1;
		ctx_s2_d.nx = MW'(speed_q) * MW'(ax_s1);
		ctx_s2_d.ny = MW'(speed_q) * MW'(ay_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s2    <= ctx_s2_d;
			sqx_s2    <= (2*C)'(ax_s1) * (2*C)'(ax_s1);
			sqy_s2    <= (2*C)'(ay_s1) * (2*C)'(ay_s1);
			spd2_s2   <= (2*SPEED_W)'(speed_q) * (2*SPEED_W)'(speed_q);
		end
	end

	// stage 3: squared distance and snap test
	logic           v_s3;
	ctx_t           ctx_s3;
	ctx_t           ctx_s3_d;
	logic [D2W-1:0] d2_s3;
	logic [D2W-1:0] d2_sum;
	logic [CW-1:0]  d2_cmp, spd_cmp;

	assign d2_sum  = D2W'(sqx_s2) + D2W'(sqy_s2);
	assign d2_cmp  = CW'(d2_sum);
	assign spd_cmp = CW'(spd2_s2);

	always_comb begin
		ctx_s3_d      = ctx_s2;
		ctx_s3_d.snap = d2_cmp <= spd_cmp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s3      <= ctx_s3_d;
			d2_s3       <= d2_sum;
		end
	end

	// square root, one digit per stage
	logic           sq_v_s    [0:P];
	ctx_t           sq_ctx_s  [0:P];
	logic [D2W:0]   sq_d2_s   [0:P];
	logic [P-1:0]   sq_root_s [0:P];
	logic [RW-1:0]  sq_rem_s  [0:P];

	assign sq_v_s[0]    = v_s3;
	assign sq_ctx_s[0]  = ctx_s3;
	assign sq_d2_s[0]   = {1'b0, d2_s3};
	assign sq_root_s[0] = '0;
	assign sq_rem_s[0]  = '0;

	for (genvar j = 0; j < P; j++) begin : g_sqrt
		localparam int I = P - 1 - j;
		logic [1:0]    two;
		logic [RW-1:0] rem_sh, trial;
		logic          ge;

		if (I >= F) begin : g_bits
			assign two = sq_d2_s[j][2*(I-F) +: 2];
		end else begin : g_zero
			assign two = 2'b00;
		end

		assign rem_sh = {sq_rem_s[j][RW-3:0], two};
		assign trial  = RW'({sq_root_s[j], 2'b01});
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[j+1] <= 1'b0;
			end else if (adv) begin
				sq_v_s[j+1] <= sq_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_ctx_s[j+1]  <= sq_ctx_s[j];
				sq_d2_s[j+1]   <= sq_d2_s[j];
				sq_rem_s[j+1]  <= ge ? rem_sh - trial : rem_sh;
				sq_root_s[j+1] <= {sq_root_s[j][P-2:0], ge};
			end
		end
	end

	// two parallel dividers, one quotient bit per stage
	logic          dv_v_s    [0:QW];
	ctx_t          dv_ctx_s  [0:QW];
	logic [P-1:0]  dv_dist_s [0:QW];
	logic [P-1:0]  dv_rx_s   [0:QW];
	logic [P-1:0]  dv_ry_s   [0:QW];
	logic [QW-1:0] dv_qx_s   [0:QW];
	logic [QW-1:0] dv_qy_s   [0:QW];
	logic [NW:0]   numx0, numy0;

	assign numx0 = {1'b0, sq_ctx_s[P].nx, {(2*F){1'b0}}};
	assign numy0 = {1'b0, sq_ctx_s[P].ny, {(2*F){1'b0}}};

	assign dv_v_s[0]    = sq_v_s[P];
	assign dv_ctx_s[0]  = sq_ctx_s[P];
	assign dv_dist_s[0] = sq_root_s[P];
	assign dv_rx_s[0]   = numx0[QW +: P];
	assign dv_ry_s[0]   = numy0[QW +: P];
	assign dv_qx_s[0]   = '0;
	assign dv_qy_s[0]   = '0;

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [NW:0] numx, numy;
		logic [P:0]  shx, shy, dvs, subx, suby;
		logic        gex, gey;

		assign numx = {1'b0, dv_ctx_s[k].nx, {(2*F){1'b0}}};
		assign numy = {1'b0, dv_ctx_s[k].ny, {(2*F){1'b0}}};
		assign dvs  = {1'b0, dv_dist_s[k]};
		assign shx  = {dv_rx_s[k], numx[QW-1-k]};
		assign shy  = {dv_ry_s[k], numy[QW-1-k]};
		assign gex  = shx >= dvs;
		assign gey  = shy >= dvs;
		assign subx = shx - dvs;
		assign suby = shy - dvs;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else if (adv) begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_ctx_s[k+1]  <= dv_ctx_s[k];
				dv_dist_s[k+1] <= dv_dist_s[k];
				dv_rx_s[k+1]   <= gex ? subx[P-1:0] : shx[P-1:0];
				dv_ry_s[k+1]   <= gey ? suby[P-1:0] : shy[P-1:0];
				dv_qx_s[k+1]   <= {dv_qx_s[k][QW-2:0], gex};
				dv_qy_s[k+1]   <= {dv_qy_s[k][QW-2:0], gey};
			end
		end
	end

	// output stage: apply step, clamp, select
	ctx_t         fc;
	logic [SW-1:0] bx, by, qx, qy, sx, sy;
	logic [SW-F-1:0] rx, ry;
	logic [C-1:0] cx, cy, nx_d, ny_d;

	assign fc = dv_ctx_s[QW];
	assign bx = SW'({fc.px, {F{1'b0}}});
	assign by = SW'({fc.py, {F{1'b0}}});
	assign qx = SW'(dv_qx_s[QW]);
	assign qy = SW'(dv_qy_s[QW]);
	assign sx = fc.dx ? bx + qx : ((qx > bx) ? '0 : bx - qx);
	assign sy = fc.dy ? by + qy : ((qy > by) ? '0 : by - qy);
	assign rx = sx[SW-1:F];
	assign ry = sy[SW-1:F];
	assign cx = (rx > (SW-F)'({C{1'b1}})) ? {C{1'b1}} : rx[C-1:0];
	assign cy = (ry > (SW-F)'({C{1'b1}})) ? {C{1'b1}} : ry[C-1:0];

	always_comb begin
		if (!fc.act) begin
			nx_d = fc.px;
			ny_d = fc.py;
		end else if (fc.snap) begin
			nx_d = fc.tx;
			ny_d = fc.ty;
		end else begin
			nx_d = cx;
			ny_d = cy;
		end
	end

	logic [C-1:0] new_x_q, new_y_q;
	logic         still_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= dv_v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			new_x_q <= nx_d;
			new_y_q <= ny_d;
			still_q <= fc.act && !fc.snap;
		end
	end

	assign out_ch.valid        = out_v_q;
	assign out_ch.new_x        = new_x_q;
	assign out_ch.new_y        = new_y_q;
	assign out_ch.still_moving = still_q;

endmodule
